// File: sv/tcw_pkg.sv
// Package for the text console writer: command codes, character codes,
// the classified-command record passed from front to back, and helpers.
// Used by tcw_front, tcw_back and text_console_writer; depends on nothing.
package tcw_pkg;

    // Default screen geometry.
    localparam int ROWS_DEFAULT = 25;
    localparam int COLS_DEFAULT = 80;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Control characters and tab advance.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [2:0] TAB_STEP   = 3'd4;

    // What the back end has to do for one command.
    typedef enum logic [2:0] {
        KIND_NEWLINE,
        KIND_TAB,
        KIND_CHAR,
        KIND_CLEAR,
        KIND_READ,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [4:0]  row;
        logic [6:0]  col;
    } op_t;

    // Handshake between the command queue and the back end.
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctl_t;

    // Cursor increment that sticks at 255.
    function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [2:0] add);
        logic [8:0] s;
        s = {1'b0, v} + 9'(add);
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

// File: sv/tcw_front.sv
// Front end of the text console writer: accepts input transactions, classifies
// each command and holds it in a two-entry queue for the back end.
// Depends on tcw_pkg.
module tcw_front #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [7:0]        char_code,
    input  logic [7:0]        color,
    input  logic [4:0]        row,
    input  logic [6:0]        col,
    input  tcw_pkg::back_ctl_t ctl,
    output logic              q_valid,
    output tcw_pkg::op_t      q_head
);

    tcw_pkg::op_t q_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    tcw_pkg::op_t op_in;
    logic         push;
    logic         rd_ok;

    // A read outside the screen behaves exactly like an unused command.
    assign rd_ok = (7'(row) < 7'(ROWS)) && (8'(col) < 8'(COLS));

    always_comb
    begin
        op_in.char_code = char_code;
        op_in.color     = color;
        op_in.row       = row;
        op_in.col       = col;
        unique case (cmd)
            tcw_pkg::CMD_PUT:
            begin
                if (char_code == tcw_pkg::CH_NEWLINE)
                    op_in.kind = tcw_pkg::KIND_NEWLINE;
                else if (char_code == tcw_pkg::CH_TAB)
                    op_in.kind = tcw_pkg::KIND_TAB;
                else
                    op_in.kind = tcw_pkg::KIND_CHAR;
            end
            tcw_pkg::CMD_CLEAR: op_in.kind = tcw_pkg::KIND_CLEAR;
            tcw_pkg::CMD_READ:  op_in.kind = rd_ok ? tcw_pkg::KIND_READ : tcw_pkg::KIND_NOP;
            default:            op_in.kind = tcw_pkg::KIND_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'd2) || ctl.init_busy;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !ctl.pop)
            count_next = count_reg + 2'd1;
        else if (!push && ctl.pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= op_in;
    end

endmodule

// File: sv/tcw_back.sv
// Back end of the text console writer: cursor, screen store, clear and scroll
// sweeps, and the output register. Depends on tcw_pkg.
module tcw_back #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tcw_pkg::op_t       q_head,
    output tcw_pkg::back_ctl_t ctl,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        cell_value,
    output logic [7:0]         cursor_col,
    output logic [7:0]         cursor_row
);

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
    localparam logic [7:0]        COL_LAST = 8'(COLS - 1);
    localparam logic [7:0]        ROW_LIM  = 8'(ROWS);
    localparam logic [7:0]        ROW_LAST = 8'(ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WRITE,
        S_SCROLL,
        S_DRAIN,
        S_CLEAR,
        S_RDWAIT,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]        cx_reg, cx_next;
    logic [7:0]        cy_reg, cy_next;
    tcw_pkg::op_t      op_reg, op_next;
    logic [15:0]       cell_reg, cell_next;
    logic              cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0] cp_dst_reg, cp_dst_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       cell_out_reg, cell_out_next;
    logic [7:0]        col_out_reg, col_out_next;
    logic [7:0]        row_out_reg, row_out_next;

    logic [15:0]       mem [DEPTH];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              load;

    assign ctl.pop       = (state_reg == S_IDLE) && q_valid;
    assign ctl.init_busy = (state_reg == S_INIT);
    assign load          = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    // Read port: the requested cell when idle, otherwise the sweep pointer.
    assign rd_addr = (state_reg == S_IDLE)
                   ? ADDR_W'(q_head.row) * COLS_A + ADDR_W'(q_head.col)
                   : ptr_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = 16'd0;
        if (state_reg == S_INIT || state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (cp_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = cp_dst_reg;
            wr_data = rd_data_reg;
        end
        else if (state_reg == S_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cy_reg) * COLS_A + ADDR_W'(cx_reg);
            wr_data = {op_reg.color, op_reg.char_code};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_comb
    begin
        logic [7:0] wx;
        logic [7:0] wy;
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        op_next       = op_reg;
        cell_next     = cell_reg;
        cp_valid_next = 1'b0;
        cp_dst_next   = cp_dst_reg;
        wx            = cx_reg;
        wy            = cy_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (ptr_reg == LAST_A)
                    state_next = S_IDLE;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next   = q_head;
                    cell_next = 16'd0;
                    state_next = S_RESP;
                    unique case (q_head.kind)
                        tcw_pkg::KIND_NEWLINE:
                        begin
                            cx_next = 8'd0;
                            cy_next = tcw_pkg::sat_add(cy_reg, 3'd1);
                        end
                        tcw_pkg::KIND_TAB:
                            cx_next = tcw_pkg::sat_add(cx_reg, tcw_pkg::TAB_STEP);
                        tcw_pkg::KIND_CHAR:
                        begin
                            if (cx_reg >= COL_LAST)
                            begin
                                wx = 8'd0;
                                wy = tcw_pkg::sat_add(cy_reg, 3'd1);
                            end
                            if (wy >= ROW_LIM)
                            begin
                                cx_next    = 8'd0;
                                cy_next    = ROW_LAST;
                                ptr_next   = COLS_A;
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                cx_next    = wx;
                                cy_next    = wy;
                                state_next = S_WRITE;
                            end
                        end
                        tcw_pkg::KIND_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        tcw_pkg::KIND_READ:
                            state_next = S_RDWAIT;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_SCROLL:
            begin
                // Read one cell a row below, write it one row up in the next cycle.
                cp_valid_next = 1'b1;
                cp_dst_next   = ptr_reg - COLS_A;
                if (ptr_reg == LAST_A)
                    state_next = S_DRAIN;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_DRAIN:
                state_next = S_WRITE;
            S_WRITE:
            begin
                cx_next    = tcw_pkg::sat_add(cx_reg, 3'd1);
                state_next = S_RESP;
            end
            S_CLEAR:
            begin
                if (ptr_reg == LAST_A)
                begin
                    cx_next    = 8'd0;
                    cy_next    = 8'd0;
                    state_next = S_RESP;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_RDWAIT:
            begin
                cell_next  = rd_data_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        out_valid_next = (out_valid_reg && out_stall) || load;
        cell_out_next  = load ? cell_reg : cell_out_reg;
        col_out_next   = load ? cx_reg : col_out_reg;
        row_out_next   = load ? cy_reg : row_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            cx_reg        <= 8'd0;
            cy_reg        <= 8'd0;
            op_reg        <= '0;
            cell_reg      <= 16'd0;
            cp_valid_reg  <= 1'b0;
            cp_dst_reg    <= '0;
            out_valid_reg <= 1'b0;
            cell_out_reg  <= 16'd0;
            col_out_reg   <= 8'd0;
            row_out_reg   <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            op_reg        <= op_next;
            cell_reg      <= cell_next;
            cp_valid_reg  <= cp_valid_next;
            cp_dst_reg    <= cp_dst_next;
            out_valid_reg <= out_valid_next;
            cell_out_reg  <= cell_out_next;
            col_out_reg   <= col_out_next;
            row_out_reg   <= row_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_out_reg;
    assign cursor_col = col_out_reg;
    assign cursor_row = row_out_reg;

endmodule

// File: sv/text_console_writer.sv
// Character-cell text console: a ROWS x COLS store of 16-bit cells, each one
// {attribute, character}, and a cursor. Every transaction on the input side
// (put character, clear screen, read cell) yields exactly one transaction on
// the output side carrying the cursor after the command and, for a read, the
// cell. Put, newline, tab, read and unused commands go from acceptance to
// the result by leaving the command queue, then, for a character write or a
// cell read, passing the write or read-wait state of the back end, and then
// loading the output register. A character that forces a scroll first has the
// row copy walk the store one cell per cycle through its single read and
// single write port; a clear walks the store the same way. After reset the
// store is swept to zero while no input is accepted.
// A two-entry command queue sits between the front end and the back end, so
// input is taken, until the queue is full, while the back end is busy or a
// result waits to be taken.
// Depends on tcw_pkg, tcw_front and tcw_back.
module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [7:0]  color,
    input  logic [4:0]  row,
    input  logic [6:0]  col,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_value,
    output logic [7:0]  cursor_col,
    output logic [7:0]  cursor_row
);

    tcw_pkg::back_ctl_t ctl;
    tcw_pkg::op_t       q_head;
    logic               q_valid;

    // The front end classifies each command and queues it.
    tcw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .char_code (char_code),
        .color     (color),
        .row       (row),
        .col       (col),
        .ctl       (ctl),
        .q_valid   (q_valid),
        .q_head    (q_head)
    );

    // The back end owns the cursor and the screen store and drives results.
    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row)
    );

endmodule

// File: sv/text_console_writer_chk.sv
// Port-level checks for the text console writer, attached by the bind below.
// Depends on text_console_writer.
module text_console_writer_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] cell_value,
    input logic [7:0]  cursor_col,
    input logic [7:0]  cursor_row
);

    // In the cycle after reset is seen low, no result is pending and no command is taken.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
        else $error("result or input open during reset");

    // The store is being cleared right after reset, so input stays closed.
    a_init_sweep: assert property (@(posedge clk) $rose(rst_n) |-> in_stall)
        else $error("input accepted before the clearing pass");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_value)
            && $stable(cursor_col) && $stable(cursor_row))
        else $error("stalled result changed");

    // A command can never be dropped onto a closed input.
    a_in_seen: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("command withdrawn while stalled");

endmodule

bind text_console_writer text_console_writer_chk u_chk (.*);

// File: tb/text_console_checker.sv
// Result checker for the text console writer: tracks command transactions,
// predicts the cursor and cell for each one and compares them with the results.
// Depends on tcw_pkg for the command and character codes.
module text_console_checker #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [7:0]  color,
    input  logic [4:0]  row,
    input  logic [6:0]  col,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] cell_value,
    input  logic [7:0]  cursor_col,
    input  logic [7:0]  cursor_row,
    output int          mismatch_count,
    output int          results_owed
);

    typedef struct packed {
        logic [15:0] cell_word;
        logic [7:0]  x;
        logic [7:0]  y;
    } console_result_t;

    logic [15:0]     screen [ROWS*COLS];
    logic [7:0]      cur_x;
    logic [7:0]      cur_y;
    console_result_t pending_results [$];
    int              error_tally;

    // Cursor step that sticks at 255.
    function automatic logic [7:0] bump(input logic [7:0] v, input int n);
        if (int'(v) + n > 255)
            return 8'hFF;
        return 8'(int'(v) + n);
    endfunction

    function automatic void wipe_display();
        foreach (screen[i])
            screen[i] = '0;
        cur_x = '0;
        cur_y = '0;
    endfunction

    function automatic void print_byte(input logic [7:0] ch, input logic [7:0] attr);
        int pos;
        if (ch == tcw_pkg::CH_NEWLINE)
        begin
            cur_x = '0;
            cur_y = bump(cur_y, 1);
        end
        else if (ch == tcw_pkg::CH_TAB)
            cur_x = bump(cur_x, int'(tcw_pkg::TAB_STEP));
        else
        begin
            if (cur_x >= COLS - 1)
            begin
                cur_x = '0;
                cur_y = bump(cur_y, 1);
            end
            // Scrolling moves every row up by one; the bottom row stays as it was.
            if (cur_y >= ROWS)
            begin
                for (int i = 0; i < (ROWS - 1) * COLS; i++)
                    screen[i] = screen[i + COLS];
                cur_x = '0;
                cur_y = 8'(ROWS - 1);
            end
            pos = int'(cur_y) * COLS + int'(cur_x);
            screen[pos] = {attr, ch};
            cur_x = bump(cur_x, 1);
        end
    endfunction

    function automatic console_result_t apply_command(input logic [1:0] c,
                                                      input logic [7:0] ch,
                                                      input logic [7:0] attr,
                                                      input logic [4:0] r,
                                                      input logic [6:0] k);
        console_result_t res;
        res = '0;
        case (c)
            tcw_pkg::CMD_PUT:   print_byte(ch, attr);
            tcw_pkg::CMD_CLEAR: wipe_display();
            tcw_pkg::CMD_READ:
                if (int'(r) < ROWS && int'(k) < COLS)
                    res.cell_word = screen[int'(r) * COLS + int'(k)];
            default: ;
        endcase
        res.x = cur_x;
        res.y = cur_y;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        console_result_t want;
        if (!rst_n)
        begin
            wipe_display();
            pending_results.delete();
            error_tally = 0;
            mismatch_count <= 0;
            results_owed <= 0;
        end
        else
        begin
            // The oldest prediction is retired before this edge's command is added.
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: cell %h col %0d row %0d",
                             $time, cell_value, cursor_col, cursor_row);
                    error_tally++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (cell_value !== want.cell_word)
                    begin
                        $display("%0t: cell_value expected %h actual %h",
                                 $time, want.cell_word, cell_value);
                        error_tally++;
                    end
                    if (cursor_col !== want.x)
                    begin
                        $display("%0t: cursor_col expected %0d actual %0d",
                                 $time, want.x, cursor_col);
                        error_tally++;
                    end
                    if (cursor_row !== want.y)
                    begin
                        $display("%0t: cursor_row expected %0d actual %0d",
                                 $time, want.y, cursor_row);
                        error_tally++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_command(cmd, char_code, color, row, col));
            mismatch_count <= error_tally;
            results_owed <= pending_results.size();
        end
    end

endmodule

// File: tb/text_console_writer_tb.sv
// Top of the text console writer testbench: clock, reset, command stimulus,
// result-side stalls, watchdog and verdict.
// Depends on tcw_pkg, text_console_writer and text_console_checker.
module text_console_writer_tb;

    // The fourth command code has no function; the block must treat it as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 700;
    // The longest quiet spell in a correct run is a clear or a scroll queued
    // behind another one, plus a long output hold.
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = tcw_pkg::CMD_PUT;
    logic [7:0]  char_code = '0;
    logic [7:0]  color = '0;
    logic [4:0]  row = '0;
    logic [6:0]  col = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] cell_value;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;

    int mismatch_count;
    int results_owed;
    int items_sent = 0;
    // Set by the stimulus to ask the result side for one long hold-off.
    bit hold_request = 1'b0;

    text_console_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_code  (char_code),
        .color      (color),
        .row        (row),
        .col        (col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row)
    );

    text_console_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .char_code      (char_code),
        .color          (color),
        .row            (row),
        .col            (col),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_value     (cell_value),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle time before a command: mostly back to back, sometimes a short
    // gap, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Mostly printable text, with an occasional byte from the full range,
    // which also brings in stray newlines, tabs and zero bytes.
    function automatic logic [7:0] text_byte();
        if ($urandom_range(99) < 90)
            return 8'($urandom_range(126, 32));
        return 8'($urandom_range(255));
    endfunction

    // Offers one command transaction and returns at the edge that accepts it.
    // The payload is only changed here, so it holds steady while stalled.
    // valid stays high from one command to the next when there is no gap,
    // so it is never lowered and raised within one time step.
    task automatic send(input logic [1:0] c, input logic [7:0] ch, input logic [7:0] attr,
                        input logic [4:0] r, input logic [6:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        char_code <= ch;
        color     <= attr;
        row       <= r;
        col       <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Row and column carry noise on a put; the block must ignore them.
    task automatic put_byte(input logic [7:0] ch, input logic [7:0] attr);
        send(tcw_pkg::CMD_PUT, ch, attr, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(input logic [4:0] r, input logic [6:0] k);
        send(tcw_pkg::CMD_READ, 8'($urandom), 8'($urandom), r, k);
    endtask

    task automatic text_line(input int len);
        repeat (len)
            put_byte(text_byte(), 8'($urandom));
    endtask

    initial
    begin : stimulus
        int kind;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. The store has just been swept, so a read of the
        // home cell must come back zero.
        read_cell(5'd0, 7'd0);
        // A zero byte is stored like any printable one, then both extremes.
        put_byte(8'h00, 8'h00);
        put_byte(8'hFF, 8'hFF);
        put_byte(8'h41, 8'h5A);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd2);
        // Last cell in range, then reads just past each edge and at the
        // very top of both fields: those must return zero.
        read_cell(5'd24, 7'd79);
        read_cell(5'd25, 7'd0);
        read_cell(5'd0, 7'd80);
        read_cell(5'd31, 7'd127);
        // The unused command leaves everything alone.
        send(CMD_UNUSED, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        put_byte(tcw_pkg::CH_NEWLINE, 8'h00);
        put_byte(tcw_pkg::CH_TAB, 8'hFF);
        put_byte(8'h78, 8'h1E);
        read_cell(5'd1, 7'd4);
        // Clear wipes the store and homes the cursor.
        send(tcw_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        read_cell(5'd0, 7'd0);
        read_cell(5'd1, 7'd4);
        text_line(3);

        // The result side now holds off for a long spell while commands keep
        // coming, so the queue fills and the block has to stall its input.
        hold_request = 1'b1;
        text_line(20);

        // Drive the row to its 255 limit with a long run of newlines, then
        // the column to its limit with tabs. The next byte has to wrap with
        // a saturated row and scroll back onto the bottom line.
        repeat ($urandom_range(262, 255))
            put_byte(tcw_pkg::CH_NEWLINE, 8'($urandom));
        repeat ($urandom_range(70, 64))
            put_byte(tcw_pkg::CH_TAB, 8'($urandom));
        text_line(2);
        read_cell(5'd24, 7'd0);
        read_cell(5'd23, 7'd0);

        // Random part: mostly runs of text, with line breaks, tabs, reads
        // around the screen, the odd clear and some noise. Once the cursor
        // reaches the bottom every wrapped line scrolls the screen.
        while (items_sent < TARGET_ITEMS)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                text_line($urandom_range(99) < 80 ? $urandom_range(30, 1)
                                                  : $urandom_range(100, 60));
            else if (kind < 60)
                repeat ($urandom_range(4, 1))
                    put_byte(tcw_pkg::CH_NEWLINE, 8'($urandom));
            else if (kind < 67)
                repeat ($urandom_range(6, 1))
                    put_byte(tcw_pkg::CH_TAB, 8'($urandom));
            else if (kind < 85)
                repeat ($urandom_range(5, 1))
                begin
                    if ($urandom_range(99) < 80)
                        read_cell(5'($urandom_range(24)), 7'($urandom_range(79)));
                    else
                        read_cell(5'($urandom), 7'($urandom));
                end
            else if (kind < 89)
                send(tcw_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom),
                     7'($urandom));
            else if (kind < 94)
                send(CMD_UNUSED, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            else
                send(2'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
        end
        in_valid <= 1'b0;
        // One more edge so that the count of owed results includes the last
        // command accepted.
        @(posedge clk);

        // Let the last results drain, then a short pad so that a stray extra
        // result would still be seen by the checker.
        while (results_owed != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side. Each cycle makes one decision for out_stall: short stalls,
    // occasional long ones, quiet stretches with no stall at all, and the one
    // long hold-off the stimulus asks for.
    initial
    begin : result_side
        int stall_left;
        int quiet_left;
        int roll;
        stall_left = 0;
        quiet_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = 300;
                quiet_left = 0;
            end
            else if (stall_left == 0 && quiet_left == 0)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    quiet_left = $urandom_range(200, 50);
                else if (roll < 12)
                    stall_left = $urandom_range(60, 10);
                else if (roll < 35)
                    stall_left = $urandom_range(3, 1);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
            end
        end
    end

    // Watchdog: too many cycles with no transaction on either side means the
    // block has hung.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: text_console_writer.f
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_writer.sv
sv/text_console_writer_chk.sv
tb/text_console_checker.sv
tb/text_console_writer_tb.sv
